// ===== rtl/core/itda_pkg.sv =====
// ----------------------------------------------------------------------------
// itda_pkg
// Shared types, character codes and helpers for the decimal text converter.
// ----------------------------------------------------------------------------
package itda_pkg;

    // Fixed width of the value_bits port
    localparam int IN_WIDTH = 64;

    // Magnitude bits folded into the BCD register per pipeline stage
    localparam int BITS_PER_STAGE = 8;

    // Opcode codes
    localparam logic OPC_UNSIGNED = 1'b0;
    localparam logic OPC_SIGNED   = 1'b1;

    // ASCII codes
    localparam logic [7:0] DIGIT_BASE = 8'h30;  // '0'
    localparam logic [7:0] DIGIT_LAST = 8'h39;  // '9'
    localparam logic [7:0] MINUS_CHAR = 8'h2D;  // '-'

    // Per-stage control that travels with the data
    typedef struct packed {
        logic valid;
        logic neg;
    } itda_ctl_t;

    // Double-dabble digit correction: add 3 to digits of 5 and above
    function automatic logic [3:0] bcd_adj(input logic [3:0] d);
        bcd_adj = (d >= 4'd5) ? d + 4'd3 : d;
    endfunction

endpackage

// ===== rtl/core/itda_dabble_stage.sv =====
// ----------------------------------------------------------------------------
// itda_dabble_stage
// One registered double-dabble stage: shifts BITS_PER_STAGE magnitude bits
// into the packed BCD digit register.
// ----------------------------------------------------------------------------
module itda_dabble_stage #(
    parameter int NDIG = 20,
    parameter int PADW = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  itda_pkg::itda_ctl_t  in_ctl,
    input  logic [NDIG*4-1:0]    in_bcd,
    input  logic [PADW-1:0]      in_rem,
    output itda_pkg::itda_ctl_t  out_ctl,
    output logic [NDIG*4-1:0]    out_bcd,
    output logic [PADW-1:0]      out_rem
);

    itda_pkg::itda_ctl_t ctl_reg;
    logic [NDIG*4-1:0]   bcd_reg;
    logic [NDIG*4-1:0]   bcd_next;
    logic [PADW-1:0]     rem_reg;
    logic [PADW-1:0]     rem_next;

    always_comb
    begin
        bcd_next = in_bcd;
        rem_next = in_rem;
        for (int s = 0; s < itda_pkg::BITS_PER_STAGE; s++)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                bcd_next[d*4 +: 4] = itda_pkg::bcd_adj(bcd_next[d*4 +: 4]);
            end
            bcd_next = {bcd_next[NDIG*4-2:0], rem_next[PADW-1]};
            rem_next = {rem_next[PADW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (load)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bcd_reg <= bcd_next;
            rem_reg <= rem_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign out_bcd = bcd_reg;
    assign out_rem = rem_reg;

endmodule

// ===== rtl/core/integer_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_core
// Converts one integer (unsigned or two's complement) into decimal ASCII,
// most significant digit first, with a leading '-' for negative values.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake           | Payload              | Per transfer
//  ---------+---------------------+----------------------+--------------------
//  input    | in_valid / in_ready | value_bits, opcode   | one number
//  output   | out_valid/out_ready | out_char, last_char  | one character
//
//  A number moves through an input register, ceil(VALUE_WIDTH/8)
//  double-dabble stages and the character emitter with its output register.
//  The emitter sends one character per cycle while the output is not stalled,
//  and takes the next number only once the last character of the current
//  one has been emitted.
//  Reset clears all valid bits and the emitter; data registers are not reset.
//  Stalls on out_ready back up through the stage valid bits without loss.
//
module integer_to_decimal_ascii_core #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [itda_pkg::IN_WIDTH-1:0] value_bits,
    input  logic                          opcode,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_char,
    output logic                          last_char
);

    // Pipeline geometry
    localparam int NS   = (VALUE_WIDTH + itda_pkg::BITS_PER_STAGE - 1)
                          / itda_pkg::BITS_PER_STAGE;
    localparam int PADW = NS * itda_pkg::BITS_PER_STAGE;
    // Decimal digits of 2^VALUE_WIDTH - 1 (log10(2) ~ 0.30103)
    localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int POSW = $clog2(NDIG);

    // ------------------------------------------------------------------
    // Input register: sign decision and magnitude
    // ------------------------------------------------------------------
    logic [VALUE_WIDTH-1:0] v_in;
    logic                   neg_in;
    logic [VALUE_WIDTH-1:0] mag_in;

    itda_pkg::itda_ctl_t    in0_ctl_reg;
    logic [VALUE_WIDTH-1:0] in0_mag_reg;

    // Stage links: index 0 is the input register, NS the last dabble stage
    itda_pkg::itda_ctl_t ctl_s [NS+1];
    logic [NDIG*4-1:0]   bcd_s [NS+1];
    logic [PADW-1:0]     rem_s [NS+1];
    logic                rdy_s [NS+2];

    assign v_in   = value_bits[VALUE_WIDTH-1:0];
    assign neg_in = (opcode == itda_pkg::OPC_SIGNED) && v_in[VALUE_WIDTH-1];
    // Unsigned negate: the most negative value maps to 2^(W-1) exactly
    assign mag_in = neg_in ? (~v_in + VALUE_WIDTH'(1)) : v_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in0_ctl_reg <= '0;
        end
        else if (rdy_s[0])
        begin
            in0_ctl_reg.valid <= in_valid;
            in0_ctl_reg.neg   <= neg_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_s[0] && in_valid)
        begin
            in0_mag_reg <= mag_in;
        end
    end

    assign ctl_s[0] = in0_ctl_reg;
    assign bcd_s[0] = '0;
    assign rem_s[0] = PADW'(in0_mag_reg);
    assign in_ready = rdy_s[0];

    // A stage takes new data when it is empty or its successor takes its own
    generate
        for (genvar k = 0; k <= NS; k++)
        begin : g_rdy
            assign rdy_s[k] = !ctl_s[k].valid || rdy_s[k+1];
        end
        for (genvar k = 1; k <= NS; k++)
        begin : g_stage
            itda_dabble_stage #(
                .NDIG (NDIG),
                .PADW (PADW)
            ) u_stage (
                .clk     (clk),
                .rst_n   (rst_n),
                .load    (rdy_s[k]),
                .in_ctl  (ctl_s[k-1]),
                .in_bcd  (bcd_s[k-1]),
                .in_rem  (rem_s[k-1]),
                .out_ctl (ctl_s[k]),
                .out_bcd (bcd_s[k]),
                .out_rem (rem_s[k])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Character emitter with output register
    // ------------------------------------------------------------------
    logic              busy_reg;
    logic              busy_next;
    logic              minus_reg;
    logic              minus_next;
    logic [POSW-1:0]   pos_reg;
    logic [POSW-1:0]   pos_next;
    logic [NDIG*4-1:0] dig_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_char_reg;
    logic [7:0]        out_char_next;
    logic              last_char_reg;
    logic              last_char_next;

    logic              load_em;
    logic              out_free;
    logic              emit;
    logic [POSW-1:0]   lead;
    logic [3:0]        cur_dig;

    assign rdy_s[NS+1] = !busy_reg;
    assign load_em     = !busy_reg && ctl_s[NS].valid;
    assign out_free    = !out_valid_reg || out_ready;
    assign emit        = busy_reg && out_free;
    assign cur_dig     = dig_reg[pos_reg*4 +: 4];

    // Position of the most significant nonzero digit; zero starts at digit 0
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_s[NS][i*4 +: 4] != 4'd0)
            begin
                lead = POSW'(i);
            end
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        minus_next     = minus_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_char_next = last_char_reg;
        if (load_em)
        begin
            busy_next  = 1'b1;
            minus_next = ctl_s[NS].neg;
            pos_next   = lead;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (minus_reg)
            begin
                out_char_next  = itda_pkg::MINUS_CHAR;
                last_char_next = 1'b0;
                minus_next     = 1'b0;
            end
            else
            begin
                out_char_next  = itda_pkg::DIGIT_BASE + 8'(cur_dig);
                last_char_next = (pos_reg == POSW'(0));
                if (pos_reg == POSW'(0))
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    pos_next = pos_reg - POSW'(1);
                end
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            minus_reg     <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            minus_reg     <= minus_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg  <= out_char_next;
        last_char_reg <= last_char_next;
        if (load_em)
        begin
            dig_reg <= bcd_s[NS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_char_reg;

endmodule

// ===== rtl/core/itda_checker.sv =====
// ----------------------------------------------------------------------------
// itda_checker
// Port-level checks on the converter's output stream.
// ----------------------------------------------------------------------------
module itda_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       last_char
);

    logic in_xfer;
    logic out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // Ready is only withdrawn after an input transfer
    a_ready_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_xfer |=> in_ready)
        else $error("in_ready dropped without a transfer");

    // Stalled output holds its character
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char)
                                    && $stable(last_char))
        else $error("output changed while stalled");

    // Only '-' or a decimal digit ever leaves
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_char == itda_pkg::MINUS_CHAR)
                      || (out_char >= itda_pkg::DIGIT_BASE
                          && out_char <= itda_pkg::DIGIT_LAST))
        else $error("character outside the decimal set");

    // A minus sign never ends a number
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_char == itda_pkg::MINUS_CHAR |-> !last_char)
        else $error("minus flagged as last character");

    // The output right after a transferred minus sign is never another minus sign
    a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && out_char == itda_pkg::MINUS_CHAR
        |=> !(out_valid && out_char == itda_pkg::MINUS_CHAR))
        else $error("two minus signs in a row");

endmodule

bind integer_to_decimal_ascii_core itda_checker u_itda_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for integer_to_decimal_ascii_core. Numbers go in over
// the input channel; every character that comes out is compared against the
// decimal text expected for that number, in order. A short directed table
// covers zero, the extremes and sign handling, then mixed random values
// follow, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int VW          = 64;
    localparam int RANDOM_NUMS = 440;
    localparam int IDLE_PCT    = 33;
    localparam int DRAIN_WAIT  = 40;

    // one character of expected text
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    logic [VW-1:0]  value_bits;
    logic           opcode;
    logic           out_valid;
    logic           out_ready;
    logic [7:0]     out_char;
    logic           last_char;

    text_char_t     expected_chars[$];
    text_char_t     head_char;
    int             errors;
    int             numbers_sent;
    int             signed_sent;
    int             negative_sent;
    int             chars_checked;
    bit             steady;         // no idling on either side while set

    integer_to_decimal_ascii_core #(
        .VALUE_WIDTH (VW)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value_bits (value_bits),
        .opcode     (opcode),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .last_char  (last_char)
    );

    // ------------------------------------------------------------------
    // Directed table. An empty text means the row is checked against the
    // predictor; otherwise the text is what the block must emit.
    // ------------------------------------------------------------------
    localparam int DIR_ROWS = 22;

    logic [63:0] dir_value [DIR_ROWS] = '{
        64'd0, 64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
        64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
        64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFF6, 64'd10000000000000000000,
        64'd999999999999999999,
        64'h0123_4567_89AB_CDEF, 64'h0123_4567_89AB_CDEF,
        64'hFEDC_BA98_7654_3210, 64'hFEDC_BA98_7654_3210,
        64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555
    };

    logic dir_opc [DIR_ROWS] = '{
        itda_pkg::OPC_UNSIGNED, itda_pkg::OPC_SIGNED, itda_pkg::OPC_UNSIGNED,
        itda_pkg::OPC_UNSIGNED, itda_pkg::OPC_UNSIGNED,
        itda_pkg::OPC_UNSIGNED, itda_pkg::OPC_SIGNED,
        itda_pkg::OPC_UNSIGNED, itda_pkg::OPC_SIGNED,
        itda_pkg::OPC_SIGNED, itda_pkg::OPC_UNSIGNED,
        itda_pkg::OPC_SIGNED, itda_pkg::OPC_UNSIGNED,
        itda_pkg::OPC_SIGNED, itda_pkg::OPC_UNSIGNED,
        itda_pkg::OPC_UNSIGNED,
        itda_pkg::OPC_UNSIGNED, itda_pkg::OPC_SIGNED,
        itda_pkg::OPC_SIGNED, itda_pkg::OPC_UNSIGNED,
        itda_pkg::OPC_SIGNED, itda_pkg::OPC_UNSIGNED
    };

    string dir_text [DIR_ROWS] = '{
        "0", "0", "1", "9", "10", "99", "100",
        "18446744073709551615", "-1",
        "-9223372036854775808", "9223372036854775808",
        "9223372036854775807", "9223372036854775807",
        "-10", "10000000000000000000",
        "", "", "", "", "", "", ""
    };

    // ------------------------------------------------------------------
    // Clock, reset
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic bit idle_now();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // ------------------------------------------------------------------
    // Predictor: decimal text of one number, pushed onto the expected queue
    // ------------------------------------------------------------------
    function automatic void predict_text(input logic [63:0] raw, input logic op);
        logic [63:0] mask;
        logic [63:0] v;
        logic [63:0] mag;
        logic        neg;
        logic [3:0]  digits[$];
        text_char_t  c;
        mask = {64{1'b1}} >> (64 - VW);
        v    = raw & mask;
        neg  = (op == itda_pkg::OPC_SIGNED) && v[VW-1];
        mag  = neg ? ((~v + 64'd1) & mask) : v;
        do begin
            digits.push_front(4'(mag % 64'd10));
            mag = mag / 64'd10;
        end while (mag != 64'd0);
        if (neg)
        begin
            c.ch   = itda_pkg::MINUS_CHAR;
            c.last = 1'b0;
            expected_chars.push_back(c);
        end
        foreach (digits[i])
        begin
            c.ch   = itda_pkg::DIGIT_BASE + {4'd0, digits[i]};
            c.last = (i == digits.size() - 1);
            expected_chars.push_back(c);
        end
    endfunction

    // typed-in text from the directed table
    function automatic void queue_literal(input string s);
        text_char_t c;
        for (int i = 0; i < s.len(); i++)
        begin
            c.ch   = s[i];
            c.last = (i == s.len() - 1);
            expected_chars.push_back(c);
        end
    endfunction

    // random value with a mix of digit counts and edge neighborhoods
    function automatic logic [63:0] pick_value();
        logic [63:0] p;
        logic [63:0] base;
        int          k;
        p = 64'd1;
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(999));
            2: return {$urandom, $urandom} >> $urandom_range(63);
            3:
            begin
                k = $urandom_range(19);
                repeat (k) p = p * 64'd10;
                return p + 64'($urandom_range(2)) - 64'd1;
            end
            4:
            begin
                case ($urandom_range(3))
                    0: base = 64'd0;
                    1: base = 64'hFFFF_FFFF_FFFF_FFFF;
                    2: base = 64'h8000_0000_0000_0000;
                    default: base = 64'h7FFF_FFFF_FFFF_FFFF;
                endcase
                return base + 64'($urandom_range(4)) - 64'd2;
            end
            default: return 64'd0 - 64'($urandom_range(1000));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side: one transfer per call, random gaps before it
    // ------------------------------------------------------------------
    task automatic send_number(input logic [63:0] v, input logic op, input string txt);
        @(negedge clk);
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        value_bits <= v;
        opcode     <= op;
        do @(posedge clk); while (!in_ready);
        // transfer happened at this edge
        if (txt.len() != 0)
            queue_literal(txt);
        else
            predict_text(v, op);
        numbers_sent++;
        if (op == itda_pkg::OPC_SIGNED)
        begin
            signed_sent++;
            if (v[VW-1])
                negative_sent++;
        end
    endtask

    // hold the input off until every pending character has come out
    task automatic drain_output();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure, compare each transfer
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !idle_now();
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected char: expected none, actual %h last %b",
                         $time, out_char, last_char);
            end
            else
            begin
                head_char = expected_chars.pop_front();
                chars_checked++;
                if (out_char !== head_char.ch)
                begin
                    errors++;
                    $display("%0t: out_char expected %h actual %h",
                             $time, head_char.ch, out_char);
                end
                if (last_char !== head_char.last)
                begin
                    errors++;
                    $display("%0t: last_char expected %b actual %b",
                             $time, head_char.last, last_char);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        errors        = 0;
        numbers_sent  = 0;
        signed_sent   = 0;
        negative_sent = 0;
        chars_checked = 0;
        steady        = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        value_bits    = '0;
        opcode        = itda_pkg::OPC_UNSIGNED;
        out_ready     = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            send_number(dir_value[r], dir_opc[r], dir_text[r]);

        // let the pipeline empty completely before the random part
        drain_output();

        for (int n = 0; n < RANDOM_NUMS; n++)
        begin
            steady = (n >= 150 && n < 230);     // back-to-back stretch
            if (n == 300)
                drain_output();
            send_number(pick_value(), 1'($urandom_range(1)), "");
        end
        steady = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        // catch any stray characters after the last expected one
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Converted %0d numbers (%0d signed, %0d negative), %0d characters checked.",
                 numbers_sent, signed_sent, negative_sent, chars_checked);
        $display("Covered zero, both extremes of each format and random digit counts.");
        if (errors == 0)
            $display("integer_to_decimal_ascii_core: match");
        else
            $display("integer_to_decimal_ascii_core: mismatch");
        $finish;
    end

    // watchdog
    initial
    begin
        #(200_000 * 12);
        $display("Timeout with %0d characters still pending.", expected_chars.size());
        $display("integer_to_decimal_ascii_core: mismatch");
        $finish;
    end

endmodule
